FILE: rtl/slss_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and register codes of the stair light sweep sequencer.
package slss_pkg;

	// Stair geometry
	localparam int unsigned LEDS_PER_STAIR = 5;
	localparam int unsigned STAIR_NUM      = 13;

	localparam logic [3:0] LAST_LED   = 4'(LEDS_PER_STAIR - 1);
	localparam logic [4:0] LAST_STAIR = 5'(STAIR_NUM - 1);

	// Sweep phases
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_LIGHT = 2'd1;
	localparam logic [1:0] PH_HOLD  = 2'd2;
	localparam logic [1:0] PH_CLEAR = 2'd3;

	// Configuration register indexes (byte address = 4 * index)
	localparam int unsigned PADDR_W = 5;
	localparam logic [2:0] REG_COLOR_RED   = 3'd0;
	localparam logic [2:0] REG_COLOR_GREEN = 3'd1;
	localparam logic [2:0] REG_COLOR_BLUE  = 3'd2;
	localparam logic [2:0] REG_LED_DELAY   = 3'd3;
	localparam logic [2:0] REG_STAIR_DELAY = 3'd4;
	localparam logic [2:0] REG_HOLD        = 3'd5;

	// Register reset values
	localparam logic [7:0]  RST_COLOR_RED   = 8'hFA;
	localparam logic [7:0]  RST_COLOR_GREEN = 8'hEB;
	localparam logic [7:0]  RST_COLOR_BLUE  = 8'hD7;
	localparam logic [15:0] RST_LED_DELAY   = 16'd10;
	localparam logic [15:0] RST_STAIR_DELAY = 16'd75;
	localparam logic [15:0] RST_HOLD        = 16'd5000;

	typedef struct packed {
		logic motion_top;
		logic motion_bottom;
	} in_t;

	typedef struct packed {
		logic       pixel_write;
		logic [8:0] pixel_index;
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
		logic       busy_res;
	} out_t;

	typedef struct packed {
		logic [7:0]  color_red;
		logic [7:0]  color_green;
		logic [7:0]  color_blue;
		logic [15:0] led_delay_ticks;
		logic [15:0] stair_delay_ticks;
		logic [15:0] hold_ticks;
	} cfg_t;

endpackage

FILE: rtl/slss_cfg.sv
`timescale 1ns / 1ps
// APB configuration registers of the stair light sweep sequencer.
module slss_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [slss_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output slss_pkg::cfg_t                cfg
);
	import slss_pkg::*;

	logic       wr_en;
	logic [2:0] reg_idx;
	cfg_t       cfg_q;

	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Write the addressed register on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_red         <= RST_COLOR_RED;
			cfg_q.color_green       <= RST_COLOR_GREEN;
			cfg_q.color_blue        <= RST_COLOR_BLUE;
			cfg_q.led_delay_ticks   <= RST_LED_DELAY;
			cfg_q.stair_delay_ticks <= RST_STAIR_DELAY;
			cfg_q.hold_ticks        <= RST_HOLD;
		end else if (wr_en) begin
			case (reg_idx)
				REG_COLOR_RED:   cfg_q.color_red         <= pwdata[7:0];
				REG_COLOR_GREEN: cfg_q.color_green       <= pwdata[7:0];
				REG_COLOR_BLUE:  cfg_q.color_blue        <= pwdata[7:0];
				REG_LED_DELAY:   cfg_q.led_delay_ticks   <= pwdata[15:0];
				REG_STAIR_DELAY: cfg_q.stair_delay_ticks <= pwdata[15:0];
				REG_HOLD:        cfg_q.hold_ticks        <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (reg_idx)
			REG_COLOR_RED:   prdata = {24'd0, cfg_q.color_red};
			REG_COLOR_GREEN: prdata = {24'd0, cfg_q.color_green};
			REG_COLOR_BLUE:  prdata = {24'd0, cfg_q.color_blue};
			REG_LED_DELAY:   prdata = {16'd0, cfg_q.led_delay_ticks};
			REG_STAIR_DELAY: prdata = {16'd0, cfg_q.stair_delay_ticks};
			REG_HOLD:        prdata = {16'd0, cfg_q.hold_ticks};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

FILE: rtl/slss_step.sv
`timescale 1ns / 1ps
// Sweep state and per-tick step logic of the stair light sweep sequencer.
module slss_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  slss_pkg::in_t   item,
	input  slss_pkg::cfg_t  cfg,
	output slss_pkg::out_t  res
);
	import slss_pkg::*;

	logic [1:0]  phase_q, phase_d;
	logic        down_q, down_d;
	logic [4:0]  stair_q, stair_d;
	logic [3:0]  led_q, led_d;
	logic [16:0] wait_q, wait_d;
	logic        tail_q, tail_d;

	logic        start;
	logic        do_write;
	logic        wr_lit;
	logic        wr_down;
	logic [4:0]  wr_stair;
	logic [3:0]  wr_led;
	logic        last_led;
	logic        last_stair;
	logic [16:0] delay;
	logic [8:0]  wr_index;

	// Pick the LED position that this tick writes
	assign start    = (phase_q == PH_IDLE) && (item.motion_top || item.motion_bottom);
	assign wr_down  = start ? item.motion_top : down_q;
	assign wr_stair = start ? (item.motion_top ? LAST_STAIR : 5'd0) : stair_q;
	assign wr_led   = start ? (item.motion_top ? LAST_LED : 4'd0) : led_q;

	assign last_led   = wr_down ? (wr_led == 4'd0) : (wr_led >= LAST_LED);
	assign last_stair = wr_down ? (wr_stair == 5'd0) : (wr_stair >= LAST_STAIR);
	assign delay      = 17'(cfg.led_delay_ticks)
		+ (last_led ? 17'(cfg.stair_delay_ticks) : 17'd0);
	assign wr_index   = 9'({4'd0, wr_stair} * 9'(LEDS_PER_STAIR)) + 9'(wr_led);

	// Decide the tick's action and next state
	always_comb begin
		phase_d  = phase_q;
		down_d   = down_q;
		stair_d  = stair_q;
		led_d    = led_q;
		wait_d   = wait_q;
		tail_d   = tail_q;
		do_write = 1'b0;
		wr_lit   = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (start) begin
				down_d   = item.motion_top;
				tail_d   = 1'b0;
				phase_d  = PH_LIGHT;
				do_write = 1'b1;
				wr_lit   = 1'b1;
			end
		end else if (wait_q > 17'd1) begin
			wait_d = wait_q - 17'd1;
		end else if (phase_q == PH_HOLD) begin
			if (tail_q) begin
				tail_d = 1'b0;
				wait_d = 17'(cfg.hold_ticks);
			end else begin
				phase_d  = PH_CLEAR;
				do_write = 1'b1;
			end
		end else if (phase_q == PH_CLEAR && tail_q) begin
			phase_d = PH_IDLE;
			tail_d  = 1'b0;
			wait_d  = 17'd0;
			stair_d = 5'd0;
			led_d   = 4'd0;
		end else begin
			do_write = 1'b1;
			wr_lit   = (phase_q == PH_LIGHT);
		end

		// Advance the position after a write
		if (do_write) begin
			wait_d = delay;
			if (last_led && last_stair) begin
				tail_d = 1'b1;
				if (wr_lit) begin
					phase_d = PH_HOLD;
					stair_d = wr_down ? LAST_STAIR : 5'd0;
					led_d   = wr_down ? LAST_LED : 4'd0;
				end else begin
					stair_d = wr_stair;
					led_d   = wr_led;
				end
			end else if (last_led) begin
				stair_d = wr_down ? wr_stair - 5'd1 : wr_stair + 5'd1;
				led_d   = wr_down ? LAST_LED : 4'd0;
			end else begin
				stair_d = wr_stair;
				led_d   = wr_down ? wr_led - 4'd1 : wr_led + 4'd1;
			end
		end
	end

	// Form the result transaction
	always_comb begin
		res.pixel_write = do_write;
		res.pixel_index = do_write ? wr_index : 9'd0;
		res.pixel_red   = (do_write && wr_lit) ? cfg.color_red : 8'd0;
		res.pixel_green = (do_write && wr_lit) ? cfg.color_green : 8'd0;
		res.pixel_blue  = (do_write && wr_lit) ? cfg.color_blue : 8'd0;
		res.busy_res    = (phase_d != PH_IDLE);
	end

	// Update the sweep state once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			down_q  <= 1'b0;
			stair_q <= 5'd0;
			led_q   <= 4'd0;
			wait_q  <= 17'd0;
			tail_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			down_q  <= down_d;
			stair_q <= stair_d;
			led_q   <= led_d;
			wait_q  <= wait_d;
			tail_q  <= tail_d;
		end
	end

	// Positions stay on the stairs, and idle means nothing is pending
	a_led_range: assert property (@(posedge clk) disable iff (!arst_n)
		led_q <= LAST_LED)
		else $error("led position past last LED");
	a_stair_range: assert property (@(posedge clk) disable iff (!arst_n)
		stair_q <= LAST_STAIR)
		else $error("stair position past last stair");
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> (wait_q == 17'd0 && !tail_q))
		else $error("idle with a pending wait");
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(phase_q) && $stable(wait_q))
		else $error("sweep state moved without an accepted tick");

endmodule

FILE: rtl/stair_light_sweep_sequencer_unit.sv
`timescale 1ns / 1ps
// Top level of the stair light sweep sequencer: handshake registers and APB port.
//
// Each input transaction is one millisecond tick with the two motion sensor
// levels, and each tick gives exactly one result transaction: an optional LED
// write (index and color) and the busy flag. The block takes one tick per
// clock cycle as long as the result is not stalled; a tick passes an input
// register and then the sweep step logic into a result register, which offers
// the result downstream. The result register lets a new tick enter while the
// previous result still waits for the downstream side; the input stalls only
// while both registers are full and the result is stalled. The user must write
// configuration over the APB port (byte address 4 * register index) only while
// no sweep is running; the block itself does not enforce it.
module stair_light_sweep_sequencer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  slss_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output slss_pkg::out_t                out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [slss_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import slss_pkg::*;

	cfg_t  cfg;
	in_t   in_data_s1;
	logic  in_valid_s1;
	out_t  step_res;
	out_t  out_data_q;
	logic  out_valid_q;
	logic  advance;

	slss_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Step the held tick when the result register can take it
	assign advance  = in_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = in_valid_s1 && !advance;

	slss_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (in_data_s1),
		.cfg     (cfg),
		.res     (step_res)
	);

	// Hold the input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_data_s1 <= in_data;
		end
	end

	// Hold the result transaction until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= step_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Input is stalled only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall && in_valid_s1))
		else $error("input stalled without downstream back-pressure");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q && $stable(out_data_q))
		else $error("stalled result transaction lost or changed");
	a_step_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("stepped tick did not reach the result register");

endmodule

FILE: tb/tb_stair_light_sweep_sequencer_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench of the stair light sweep sequencer: sweeps, timing, registers, stalls.
module tb_stair_light_sweep_sequencer_unit;
	import slss_pkg::*;

	// Register indexes past the end of the list
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	localparam int GAP_PERCENT = 28;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	in_t                 in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	out_t                out_data;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;

	// Predicted sweep state and register copy
	logic [1:0]  sweep_phase;
	logic        sweep_dn;
	logic [4:0]  stair_at;
	logic [3:0]  led_at;
	logic [16:0] ticks_left;
	logic        tail_wait;
	cfg_t        cfg_now;

	out_t        expected_pixels[$];
	out_t        want_px;
	int          mismatches = 0;
	int          ticks_sent = 0;
	int          hold_off_left = 0;
	bit          in_gaps = 1'b1;
	bit          out_gaps = 1'b1;

	stair_light_sweep_sequencer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Move to the first LED of the current sweep direction
	function automatic void start_point();
		if (sweep_dn) begin
			stair_at = LAST_STAIR;
			led_at = LAST_LED;
		end else begin
			stair_at = '0;
			led_at = '0;
		end
	endfunction

	// Write the LED under the cursor, load the following wait, advance the cursor
	function automatic out_t write_pixel();
		out_t px;
		logic lit;
		logic last_led;
		logic last_stair;
		px = '0;
		lit = (sweep_phase == PH_LIGHT);
		px.pixel_write = 1'b1;
		px.pixel_index = 9'(stair_at * LEDS_PER_STAIR + led_at);
		px.pixel_red = lit ? cfg_now.color_red : 8'd0;
		px.pixel_green = lit ? cfg_now.color_green : 8'd0;
		px.pixel_blue = lit ? cfg_now.color_blue : 8'd0;
		last_led = sweep_dn ? (led_at == 4'd0) : (led_at >= LAST_LED);
		last_stair = sweep_dn ? (stair_at == 5'd0) : (stair_at >= LAST_STAIR);
		ticks_left = 17'(cfg_now.led_delay_ticks)
			+ (last_led ? 17'(cfg_now.stair_delay_ticks) : 17'd0);
		if (last_led && last_stair) begin
			tail_wait = 1'b1;
			if (lit) begin
				sweep_phase = PH_HOLD;
				start_point();
			end
		end else if (last_led) begin
			if (sweep_dn) begin
				stair_at = stair_at - 5'd1;
				led_at = LAST_LED;
			end else begin
				stair_at = stair_at + 5'd1;
				led_at = '0;
			end
		end else begin
			led_at = sweep_dn ? led_at - 4'd1 : led_at + 4'd1;
		end
		return px;
	endfunction

	// Advance the predicted sequencer by one millisecond tick
	function automatic out_t next_tick(in_t t);
		out_t px;
		px = '0;
		if (sweep_phase == PH_IDLE) begin
			if (t.motion_top || t.motion_bottom) begin
				sweep_dn = t.motion_top;
				start_point();
				tail_wait = 1'b0;
				sweep_phase = PH_LIGHT;
				px = write_pixel();
			end
		end else if (ticks_left > 17'd1) begin
			ticks_left = ticks_left - 17'd1;
		end else if (sweep_phase == PH_HOLD) begin
			if (tail_wait) begin
				tail_wait = 1'b0;
				ticks_left = 17'(cfg_now.hold_ticks);
			end else begin
				sweep_phase = PH_CLEAR;
				px = write_pixel();
			end
		end else if (sweep_phase == PH_CLEAR && tail_wait) begin
			sweep_phase = PH_IDLE;
			tail_wait = 1'b0;
			ticks_left = '0;
			stair_at = '0;
			led_at = '0;
		end else begin
			px = write_pixel();
		end
		px.busy_res = (sweep_phase != PH_IDLE);
		return px;
	endfunction

	task automatic log_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%t mismatch: %s", $realtime, what);
	endtask

	// Receiver: random stall, long hold-off on request, check every result transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				log_mismatch($sformatf("unexpected result wr=%0d idx=%0d rgb=%02h%02h%02h busy=%0d",
					out_data.pixel_write, out_data.pixel_index, out_data.pixel_red,
					out_data.pixel_green, out_data.pixel_blue, out_data.busy_res));
			end else begin
				want_px = expected_pixels.pop_front();
				if (out_data.pixel_write !== want_px.pixel_write
						|| out_data.pixel_index !== want_px.pixel_index
						|| out_data.pixel_red !== want_px.pixel_red
						|| out_data.pixel_green !== want_px.pixel_green
						|| out_data.pixel_blue !== want_px.pixel_blue
						|| out_data.busy_res !== want_px.busy_res) begin
					log_mismatch($sformatf(
						"expected wr=%0d idx=%0d rgb=%02h%02h%02h busy=%0d, got wr=%0d idx=%0d rgb=%02h%02h%02h busy=%0d",
						want_px.pixel_write, want_px.pixel_index, want_px.pixel_red,
						want_px.pixel_green, want_px.pixel_blue, want_px.busy_res,
						out_data.pixel_write, out_data.pixel_index, out_data.pixel_red,
						out_data.pixel_green, out_data.pixel_blue, out_data.busy_res));
				end
			end
		end
		if (hold_off_left > 0) begin
			out_stall <= 1'b1;
			hold_off_left--;
		end else begin
			out_stall <= out_gaps && ($urandom_range(99) < GAP_PERCENT);
		end
	end

	// Offer one tick, hold it until accepted, then record its predicted result
	task automatic send_tick(input in_t t);
		while (in_gaps && $urandom_range(99) < GAP_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		do
			@(posedge clk);
		while (in_stall);
		expected_pixels.push_back(next_tick(t));
		ticks_sent++;
	endtask

	// Drop valid and wait for every outstanding result transaction
	task automatic wait_all_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_pixels.size() != 0);
	endtask

	// Keep ticking until the predicted sweep is over
	task automatic run_to_idle(input in_t fixed, input bit scramble);
		while (sweep_phase != PH_IDLE)
			send_tick(scramble ? in_t'(2'($urandom_range(0, 3))) : fixed);
	endtask

	// Mostly quiet sensors, sometimes motion on either or both
	function automatic in_t idle_motion();
		return ($urandom_range(99) < 70) ? in_t'(2'b00) : in_t'(2'($urandom_range(1, 3)));
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_COLOR_RED: cfg_now.color_red = val[7:0];
			REG_COLOR_GREEN: cfg_now.color_green = val[7:0];
			REG_COLOR_BLUE: cfg_now.color_blue = val[7:0];
			REG_LED_DELAY: cfg_now.led_delay_ticks = val[15:0];
			REG_STAIR_DELAY: cfg_now.stair_delay_ticks = val[15:0];
			REG_HOLD: cfg_now.hold_ticks = val[15:0];
			default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic verify_reg(input logic [2:0] idx, input logic [31:0] want);
		logic [31:0] got;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= PADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== want)
			log_mismatch($sformatf("register %0d read %h, expected %h", idx, got, want));
	endtask

	task automatic check_regs();
		verify_reg(REG_COLOR_RED, 32'(cfg_now.color_red));
		verify_reg(REG_COLOR_GREEN, 32'(cfg_now.color_green));
		verify_reg(REG_COLOR_BLUE, 32'(cfg_now.color_blue));
		verify_reg(REG_LED_DELAY, 32'(cfg_now.led_delay_ticks));
		verify_reg(REG_STAIR_DELAY, 32'(cfg_now.stair_delay_ticks));
		verify_reg(REG_HOLD, 32'(cfg_now.hold_ticks));
	endtask

	// Write every register with junk above its width; only while no sweep runs
	task automatic load_config(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic [15:0] led_d, input logic [15:0] stair_d, input logic [15:0] hold_d);
		wait_all_results();
		apb_write(REG_COLOR_RED, {24'($urandom), r});
		apb_write(REG_COLOR_GREEN, {24'($urandom), g});
		apb_write(REG_COLOR_BLUE, {24'($urandom), b});
		apb_write(REG_LED_DELAY, {16'($urandom), led_d});
		apb_write(REG_STAIR_DELAY, {16'($urandom), stair_d});
		apb_write(REG_HOLD, {16'($urandom), hold_d});
	endtask

	// Reset values read back; then one downward sweep in the reset color with short
	// stair and hold waits, top sensor held high throughout and bottom after the first tick
	task automatic test_reset_defaults();
		check_regs();
		repeat (3) send_tick(in_t'(2'b00));
		wait_all_results();
		apb_write(REG_LED_DELAY, 32'd0);
		apb_write(REG_STAIR_DELAY, 32'd2);
		apb_write(REG_HOLD, 32'd5);
		send_tick(in_t'(2'b10));
		run_to_idle(in_t'(2'b11), 1'b0);
	endtask

	// Register extremes, out-of-range indexes, readback
	task automatic test_register_access();
		load_config(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		check_regs();
		apb_write(REG_SPARE_LO, $urandom);
		apb_write(REG_SPARE_HI, $urandom);
		check_regs();
		load_config(8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000);
		check_regs();
	endtask

	// Zero delays, upward sweep with no idling on either side, top sensor ignored while busy
	task automatic test_upward_zero_delay();
		load_config(8'hFF, 8'h00, 8'hFF, 16'd0, 16'd0, 16'd0);
		in_gaps = 1'b0;
		out_gaps = 1'b0;
		send_tick(in_t'(2'b00));
		send_tick(in_t'(2'b01));
		run_to_idle(in_t'(2'b10), 1'b0);
		in_gaps = 1'b1;
		out_gaps = 1'b1;
	endtask

	// Both sensors on the tick right after a sweep ends: top wins; unit delays
	task automatic test_top_wins_unit_delays();
		load_config(8'h00, 8'hFF, 8'h00, 16'd1, 16'd1, 16'd1);
		send_tick(in_t'(2'b11));
		repeat (20) send_tick(in_t'(2'($urandom_range(0, 3))));
	endtask

	// Receiver holds off while ticks keep coming mid sweep; then sender pauses
	task automatic test_backpressure();
		hold_off_left = 300;
		repeat (80) send_tick(in_t'(2'($urandom_range(0, 3))));
		wait_all_results();
		run_to_idle('0, 1'b1);
	endtask

	// Random settings, at least one sweep per setting with random idle traffic around it
	task automatic test_random_sweeps();
		while (ticks_sent < 550) begin
			load_config(pick_byte(), pick_byte(), pick_byte(), 16'($urandom_range(0, 1)),
				16'($urandom_range(0, 3)), 16'($urandom_range(0, 6)));
			while (sweep_phase == PH_IDLE)
				send_tick(idle_motion());
			run_to_idle('0, 1'b1);
			repeat ($urandom_range(0, 5)) send_tick(idle_motion());
			run_to_idle('0, 1'b1);
		end
	endtask

	initial begin
		sweep_phase = PH_IDLE;
		sweep_dn = 1'b0;
		stair_at = '0;
		led_at = '0;
		ticks_left = '0;
		tail_wait = 1'b0;
		cfg_now = '{RST_COLOR_RED, RST_COLOR_GREEN, RST_COLOR_BLUE,
			RST_LED_DELAY, RST_STAIR_DELAY, RST_HOLD};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_access();
		test_upward_zero_delay();
		test_top_wins_unit_delays();
		test_backpressure();
		test_random_sweeps();

		wait_all_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("PASS stair_light_sweep_sequencer_unit");
		end else begin
			$display("FAIL stair_light_sweep_sequencer_unit");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("FAIL stair_light_sweep_sequencer_unit");
		$finish;
	end

endmodule

FILE: sim.f
rtl/slss_pkg.sv
rtl/slss_cfg.sv
rtl/slss_step.sv
rtl/stair_light_sweep_sequencer_unit.sv
tb/tb_stair_light_sweep_sequencer_unit.sv
